@@ rtl/snf_pkg.sv @@
`timescale 1ns / 1ps

package snf_pkg;

  // Number of digit positions on the display.
  localparam int DIGITS = 4;

  // Largest value that is shown in decimal.
  localparam logic [14:0] MAX_VALUE = 15'd9999;

  // Fixed bytes of the bus transaction.
  localparam logic [7:0] SEG_DASH   = 8'h40;
  localparam logic [7:0] SEG_BLANK  = 8'h00;
  localparam logic [7:0] ADDR_FIRST = 8'hc0;

  // Reset values of the command registers.
  localparam logic [7:0] DATA_CMD_RESET    = 8'd64;
  localparam logic [7:0] DISPLAY_CMD_RESET = 8'd152;

  // Register indexes on the configuration port.
  localparam logic CFG_DATA_CMD    = 1'b0;
  localparam logic CFG_DISPLAY_CMD = 1'b1;

  // Bus token codes.
  typedef enum logic [1:0] {
    TOK_START = 2'd0,
    TOK_BYTE  = 2'd1,
    TOK_STOP  = 2'd2
  } tok_kind_t;

  // Value split into hundreds and remainder, with the out-of-range flag.
  typedef struct packed {
    logic       dash;
    logic [6:0] hi;
    logic [6:0] lo;
  } split_t;

  // Segment bytes, index 0 is the most significant digit.
  typedef logic [DIGITS-1:0][7:0] seg_bytes_t;

  // Common-cathode seven-segment code of one decimal digit.
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5b;
      4'd3:    code = 8'h4f;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h7d;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'h6f;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/snf_digit_split.sv @@
`timescale 1ns / 1ps

module snf_digit_split (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  logic [15:0]           in_value,
  output logic                  in_rdy,
  output logic                  out_vld,
  output snf_pkg::split_t       out_split,
  input  logic                  out_rdy
);

  logic          v_vld;
  logic [15:0]   v;
  logic          v_adv;
  logic [26:0]   prod;
  logic [6:0]    quot;
  logic [13:0]   rem;
  snf_pkg::split_t split_next;

  assign v_adv  = v_vld && (!out_vld || out_rdy);
  assign in_rdy = !v_vld || v_adv;

  // Divide by one hundred through a reciprocal; exact for values up to 9999.
  assign prod = {13'd0, v[13:0]} * 27'd5243;
  assign quot = prod[25:19];
  assign rem  = v[13:0] - ({7'd0, quot} * 14'd100);

  always_comb begin
    split_next.dash = v[15] || (v[14:0] > snf_pkg::MAX_VALUE);
    split_next.hi   = quot;
    split_next.lo   = rem[6:0];
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_vld <= 1'b0;
    end else if (in_vld && in_rdy) begin
      v_vld <= 1'b1;
    end else if (v_adv) begin
      v_vld <= 1'b0;
    end
    if (in_vld && in_rdy) begin
      v <= in_value;
    end
  end

  // Split register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (v_adv) begin
      out_vld <= 1'b1;
    end else if (out_rdy) begin
      out_vld <= 1'b0;
    end
    if (v_adv) begin
      out_split <= split_next;
    end
  end

endmodule

@@ rtl/snf_seg_encode.sv @@
`timescale 1ns / 1ps

module snf_seg_encode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  snf_pkg::split_t       in_split,
  output logic                  in_rdy,
  output logic                  out_vld,
  output snf_pkg::seg_bytes_t   out_segs,
  input  logic                  out_rdy
);

  logic [14:0] hi_prod;
  logic [14:0] lo_prod;
  logic [3:0]  d_thou;
  logic [3:0]  d_hund;
  logic [3:0]  d_tens;
  logic [3:0]  d_ones;
  logic [7:0]  hi_rem;
  logic [7:0]  lo_rem;
  snf_pkg::seg_bytes_t segs_next;

  assign in_rdy = !out_vld || out_rdy;

  // Split each two-digit half into tens and ones; x*205>>11 is x/10 below 100.
  assign hi_prod = {8'd0, in_split.hi} * 15'd205;
  assign lo_prod = {8'd0, in_split.lo} * 15'd205;
  assign d_thou  = hi_prod[14:11];
  assign d_tens  = lo_prod[14:11];
  assign hi_rem  = {1'b0, in_split.hi} - ({4'd0, d_thou} * 8'd10);
  assign lo_rem  = {1'b0, in_split.lo} - ({4'd0, d_tens} * 8'd10);
  assign d_hund  = hi_rem[3:0];
  assign d_ones  = lo_rem[3:0];

  // Map digits to segment codes and blank the leading zeros; out-of-range values show dashes.
  always_comb begin
    if (in_split.dash) begin
      segs_next = {snf_pkg::DIGITS{snf_pkg::SEG_DASH}};
    end else begin
      segs_next[0] = (in_split.hi >= 7'd10) ? snf_pkg::seg_code(d_thou) : snf_pkg::SEG_BLANK;
      segs_next[1] = (in_split.hi != 7'd0) ? snf_pkg::seg_code(d_hund) : snf_pkg::SEG_BLANK;
      segs_next[2] = ((in_split.hi != 7'd0) || (in_split.lo >= 7'd10)) ?
                     snf_pkg::seg_code(d_tens) : snf_pkg::SEG_BLANK;
      segs_next[3] = snf_pkg::seg_code(d_ones);
    end
  end

  // Segment register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (in_vld && in_rdy) begin
      out_vld <= 1'b1;
    end else if (out_rdy) begin
      out_vld <= 1'b0;
    end
    if (in_vld && in_rdy) begin
      out_segs <= segs_next;
    end
  end

endmodule

@@ rtl/snf_token_seq.sv @@
`timescale 1ns / 1ps

module snf_token_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  snf_pkg::seg_bytes_t   in_segs,
  output logic                  in_rdy,
  input  logic [7:0]            data_command,
  input  logic [7:0]            display_command,
  output logic                  strobe,
  output logic [1:0]            token_kind,
  output logic [7:0]            byte_value,
  output logic                  last_token
);

  // Token positions within one update.
  localparam logic [3:0] POS_START_A = 4'd0;
  localparam logic [3:0] POS_DATA    = 4'd1;
  localparam logic [3:0] POS_STOP_A  = 4'd2;
  localparam logic [3:0] POS_START_B = 4'd3;
  localparam logic [3:0] POS_ADDR    = 4'd4;
  localparam logic [3:0] POS_SEG0    = 4'd5;
  localparam logic [3:0] POS_SEG1    = 4'd6;
  localparam logic [3:0] POS_SEG2    = 4'd7;
  localparam logic [3:0] POS_SEG3    = 4'd8;
  localparam logic [3:0] POS_STOP_B  = 4'd9;
  localparam logic [3:0] POS_START_C = 4'd10;
  localparam logic [3:0] POS_DISPLAY = 4'd11;
  localparam logic [3:0] POS_LAST    = 4'd12;

  logic                act;
  logic [3:0]          cnt;
  snf_pkg::seg_bytes_t segs;
  snf_pkg::tok_kind_t  kind_next;
  logic [7:0]          byte_next;
  logic                load;

  // A new update may start in the cycle after the final stop is issued.
  assign in_rdy = !act || (cnt == POS_LAST);
  assign load   = in_vld && in_rdy;

  // Token at the current position.
  always_comb begin
    kind_next = snf_pkg::TOK_BYTE;
    byte_next = 8'd0;
    case (cnt)
      POS_START_A, POS_START_B, POS_START_C: kind_next = snf_pkg::TOK_START;
      POS_STOP_A, POS_STOP_B, POS_LAST:      kind_next = snf_pkg::TOK_STOP;
      POS_DATA:    byte_next = data_command;
      POS_ADDR:    byte_next = snf_pkg::ADDR_FIRST;
      POS_SEG0:    byte_next = segs[0];
      POS_SEG1:    byte_next = segs[1];
      POS_SEG2:    byte_next = segs[2];
      POS_SEG3:    byte_next = segs[3];
      POS_DISPLAY: byte_next = display_command;
      default:     kind_next = snf_pkg::TOK_STOP;
    endcase
  end

  // Position counter and held segment bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
      cnt <= POS_START_A;
    end else if (load) begin
      act <= 1'b1;
      cnt <= POS_START_A;
    end else if (act && (cnt == POS_LAST)) begin
      act <= 1'b0;
    end else if (act) begin
      cnt <= cnt + 4'd1;
    end
    if (load) begin
      segs <= in_segs;
    end
  end

  // Result register: one beat per cycle while an update is running.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= act;
    end
    token_kind <= kind_next;
    byte_value <= byte_next;
    last_token <= act && (cnt == POS_LAST);
  end

  // The final stop always closes the update.
  a_last_is_stop: assert property (@(posedge clk) disable iff (rst)
    strobe && last_token |-> token_kind == snf_pkg::TOK_STOP && byte_value == 8'd0)
    else $error("last beat is not a stop token");

  // An update runs without a gap until its final stop.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    act && (cnt != POS_LAST) |=> act && (cnt == $past(cnt) + 4'd1))
    else $error("token sequence broke off early");

  // Every update opens with a start token.
  a_open_start: assert property (@(posedge clk) disable iff (rst)
    load |=> ##1 strobe && token_kind == snf_pkg::TOK_START && !last_token)
    else $error("update did not open with a start token");

endmodule

@@ rtl/seven_segment_number_framer_top.sv @@
`timescale 1ns / 1ps

// Seven-segment number framer. Each value accepted (start high while busy is
// low) produces thirteen bus tokens, one per cycle on consecutive cycles,
// each marked by strobe for one cycle: start, data command, stop; start,
// address 0xc0, four segment bytes, stop; start, display command, stop with
// last_token set. The receiver cannot stall, so it must take a beat in every
// cycle that strobe is high. An accepted value passes the input, split and
// segment registers before the token sequencer loads it; the sequencer
// issues one token per cycle, which bounds the sustained rate. Three values
// can wait in the conversion stages behind it, and busy goes high once they
// are full. Values outside 0 to 9999 show four dashes. The command registers
// are written at any edge with cfg_wr high, and are read while tokens go out.

module seven_segment_number_framer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] value,
  input  logic        cfg_wr,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        strobe,
  output logic [1:0]  token_kind,
  output logic [7:0]  byte_value,
  output logic        last_token
);

  logic                in_rdy;
  logic                sp_vld;
  logic                sp_rdy;
  snf_pkg::split_t     sp_data;
  logic                sg_vld;
  logic                sg_rdy;
  snf_pkg::seg_bytes_t sg_data;
  logic [7:0]          data_command;
  logic [7:0]          display_command;

  assign busy = !in_rdy;

  // Command registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_command    <= snf_pkg::DATA_CMD_RESET;
      display_command <= snf_pkg::DISPLAY_CMD_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        snf_pkg::CFG_DATA_CMD:    data_command    <= cfg_data;
        snf_pkg::CFG_DISPLAY_CMD: display_command <= cfg_data;
        default: ;
      endcase
    end
  end

  snf_digit_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (start),
    .in_value  (value),
    .in_rdy    (in_rdy),
    .out_vld   (sp_vld),
    .out_split (sp_data),
    .out_rdy   (sp_rdy)
  );

  snf_seg_encode u_encode (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sp_vld),
    .in_split (sp_data),
    .in_rdy   (sp_rdy),
    .out_vld  (sg_vld),
    .out_segs (sg_data),
    .out_rdy  (sg_rdy)
  );

  snf_token_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .in_vld          (sg_vld),
    .in_segs         (sg_data),
    .in_rdy          (sg_rdy),
    .data_command    (data_command),
    .display_command (display_command),
    .strobe          (strobe),
    .token_kind      (token_kind),
    .byte_value      (byte_value),
    .last_token      (last_token)
  );

endmodule

@@ tb/seven_segment_number_framer_check.sv @@
`timescale 1ns / 1ps

// Watches the value, command register and token channels of the framer. For
// each accepted value it works out the thirteen bus tokens that must follow,
// and it compares every token beat that comes out with the oldest one owed.
module seven_segment_number_framer_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] value,
  input  logic        cfg_wr,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        strobe,
  input  logic [1:0]  token_kind,
  input  logic [7:0]  byte_value,
  input  logic        last_token,
  output int          mismatches,
  output int          tokens_owed
);

  typedef struct packed {
    snf_pkg::tok_kind_t kind;
    logic [7:0]         data;
    logic               last;
  } bus_token_t;

  // Common-cathode glyphs for the digits 0 to 9.
  localparam logic [7:0] GLYPH [0:9] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  logic [7:0] data_cmd;
  logic [7:0] display_cmd;
  bus_token_t owed_tokens [$];
  int         tokens_seen;

  // Segment bytes for one value, most significant position first. Anything
  // negative or above the four-digit range shows dashes; leading zeros are
  // blanked, but zero keeps its single digit.
  function automatic snf_pkg::seg_bytes_t shown_segments(input logic signed [15:0] v);
    snf_pkg::seg_bytes_t segs;
    int n;
    int lit;
    n = v;
    if (n < 0 || n > int'(snf_pkg::MAX_VALUE)) begin
      for (int i = 0; i < snf_pkg::DIGITS; i++) segs[i] = snf_pkg::SEG_DASH;
    end else begin
      lit = (n > 999) ? 4 : (n > 99) ? 3 : (n > 9) ? 2 : 1;
      for (int i = snf_pkg::DIGITS - 1; i >= 0; i--) begin
        segs[i] = (snf_pkg::DIGITS - 1 - i < lit) ? GLYPH[n % 10] : snf_pkg::SEG_BLANK;
        n = n / 10;
      end
    end
    return segs;
  endfunction

  task automatic owe(input snf_pkg::tok_kind_t k, input logic [7:0] d, input logic l);
    bus_token_t t;
    t.kind = k;
    t.data = d;
    t.last = l;
    owed_tokens.push_back(t);
  endtask

  // One display update: data command, address and digits, display control.
  task automatic owe_update(input logic [15:0] v);
    snf_pkg::seg_bytes_t segs;
    segs = shown_segments(v);
    owe(snf_pkg::TOK_START, 8'h00, 1'b0);
    owe(snf_pkg::TOK_BYTE, data_cmd, 1'b0);
    owe(snf_pkg::TOK_STOP, 8'h00, 1'b0);
    owe(snf_pkg::TOK_START, 8'h00, 1'b0);
    owe(snf_pkg::TOK_BYTE, snf_pkg::ADDR_FIRST, 1'b0);
    for (int i = 0; i < snf_pkg::DIGITS; i++) owe(snf_pkg::TOK_BYTE, segs[i], 1'b0);
    owe(snf_pkg::TOK_STOP, 8'h00, 1'b0);
    owe(snf_pkg::TOK_START, 8'h00, 1'b0);
    owe(snf_pkg::TOK_BYTE, display_cmd, 1'b0);
    owe(snf_pkg::TOK_STOP, 8'h00, 1'b1);
  endtask

  initial begin
    mismatches  = 0;
    tokens_owed = 0;
    tokens_seen = 0;
  end

  always @(posedge clk) begin
    bus_token_t want;
    if (rst) begin
      data_cmd    = snf_pkg::DATA_CMD_RESET;
      display_cmd = snf_pkg::DISPLAY_CMD_RESET;
      owed_tokens.delete();
    end else begin
      // Token beats are taken in every cycle that strobe is high.
      if (strobe === 1'b1) begin
        if (owed_tokens.size() == 0) begin
          if (mismatches < 10)
            $display("token %0d: none owed, got kind %0d byte %02h last %0b",
                     tokens_seen, token_kind, byte_value, last_token);
          mismatches++;
        end else begin
          want = owed_tokens.pop_front();
          if (token_kind !== want.kind || byte_value !== want.data ||
              last_token !== want.last) begin
            if (mismatches < 10)
              $display("token %0d: expected %0d %02h %0b, got %0d %02h %0b",
                       tokens_seen, want.kind, want.data, want.last,
                       token_kind, byte_value, last_token);
            mismatches++;
          end
        end
        tokens_seen++;
      end
      // Command register writes take effect at once.
      if (cfg_wr === 1'b1) begin
        if (cfg_index == snf_pkg::CFG_DATA_CMD) data_cmd = cfg_data;
        else if (cfg_index == snf_pkg::CFG_DISPLAY_CMD) display_cmd = cfg_data;
      end
      // A value beat is taken when start is high and busy is low.
      if (start === 1'b1 && busy === 1'b0) owe_update(value);
    end
    tokens_owed = owed_tokens.size();
  end

endmodule

@@ tb/seven_segment_number_framer_top_test.sv @@
`timescale 1ns / 1ps

module seven_segment_number_framer_top_test;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 50;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] value;
  logic        cfg_wr;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        strobe;
  logic [1:0]  token_kind;
  logic [7:0]  byte_value;
  logic        last_token;
  int          mismatches;
  int          tokens_owed;
  int          quiet_cycles;
  bit          bursty;

  // Edge values of the field, each digit count and every out-of-range class.
  int corner_values [20] = '{
    0, 1, 9, 10, 99, 100, 999, 1000, 1234, 5678, 9090, 9999, 10000,
    -1, -999, -1000, 32767, -32768, 21845, -21846
  };

  always #4 clk = ~clk;

  seven_segment_number_framer_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .cfg_wr     (cfg_wr),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .strobe     (strobe),
    .token_kind (token_kind),
    .byte_value (byte_value),
    .last_token (last_token)
  );

  seven_segment_number_framer_check u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value       (value),
    .cfg_wr      (cfg_wr),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .token_kind  (token_kind),
    .byte_value  (byte_value),
    .last_token  (last_token),
    .mismatches  (mismatches),
    .tokens_owed (tokens_owed)
  );

  // Ends the run if neither a value nor a token beat moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Mostly numbers that fit, with a random count of digits; the rest are
  // negative, too large or wholly random.
  function automatic logic [15:0] draw_value();
    int pick;
    int lit;
    int n;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      lit = $urandom_range(1, 4);
      case (lit)
        1:       n = $urandom_range(0, 9);
        2:       n = $urandom_range(10, 99);
        3:       n = $urandom_range(100, 999);
        default: n = $urandom_range(1000, 9999);
      endcase
    end else if (pick == 6) begin
      n = -int'($urandom_range(1, 999));
    end else if (pick == 7) begin
      n = $urandom_range(10000, 32767);
    end else begin
      n = $urandom();
    end
    return n[15:0];
  endfunction

  // Offers one value after a random gap and returns at the edge that takes
  // it, with start still high so that a back-to-back value can follow.
  task automatic send_value(input int n);
    int gap;
    gap = bursty ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= n[15:0];
    do @(posedge clk); while (busy);
  endtask

  // Holds off until every owed token has come out.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (tokens_owed != 0);
    @(posedge clk);
  endtask

  task automatic load_commands(input logic [7:0] dcmd, input logic [7:0] pcmd);
    cfg_wr    <= 1'b1;
    cfg_index <= snf_pkg::CFG_DATA_CMD;
    cfg_data  <= dcmd;
    @(posedge clk);
    cfg_index <= snf_pkg::CFG_DISPLAY_CMD;
    cfg_data  <= pcmd;
    @(posedge clk);
    cfg_wr    <= 1'b0;
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    value     <= 16'h0000;
    cfg_wr    <= 1'b0;
    cfg_index <= snf_pkg::CFG_DATA_CMD;
    cfg_data  <= 8'h00;
    bursty    = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed values under the reset commands, half of them back to back.
    foreach (corner_values[i]) begin
      bursty = (i >= 10);
      send_value(corner_values[i]);
    end

    // Random phases, each under its own pair of command bytes.
    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0:       load_commands(8'h00, 8'h00);
        1:       load_commands(8'hff, 8'hff);
        2:       load_commands(8'hff, 8'h00);
        default: load_commands(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 10 == 0) bursty = ($urandom_range(0, 3) == 0);
        send_value(int'(draw_value()));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && tokens_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
